// ----- rtl/dspadpcm_pkg.sv -----
// ----------------------------------------------------------------------------
// dspadpcm_pkg
// Types and constants shared by the controller, the datapath and the top level
// of the two-tap ADPCM decoder.
// ----------------------------------------------------------------------------
package dspadpcm_pkg;

   // Frame layout: one header byte followed by data bytes.
   localparam int FRAME_BYTES = 8;
   localparam int POS_W       = $clog2(FRAME_BYTES);

   // Configuration port.
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 64;
   localparam int NUM_COEF_REGS = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_COEFS_0_1    = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COEFS_2_3    = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_COEFS_4_5    = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_COEFS_6_7    = 8'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_INIT_HISTORY = 8'd4;

   // Arithmetic. The scaled nibble reaches 2^29 in magnitude and each product
   // 2^30, so a 34-bit signed accumulator can never overflow.
   localparam int SAMPLE_W   = 16;
   localparam int ACC_W      = 34;
   localparam int FRAC_BITS  = 11;
   localparam int RES_W      = ACC_W - FRAC_BITS;
   localparam int ROUND_BIAS = 1024;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -16'sh8000;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_history;  // restart: take the history from initial_history
      logic load_header;   // latch scale shift and predictor index
      logic load_byte;     // latch a data byte
      logic do_mul;        // form the products for one nibble
      logic nibble_lo;     // select the low nibble for do_mul
      logic do_add;        // finish a sample, shift the history, fill output
      logic last;          // the sample finished is the second of its byte
      logic write_err;     // fill the output with an error result
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic header_bad;    // predictor index of the offered byte is above 7
   } dp_status_type;

endpackage

// ----- rtl/dspadpcm_ctrl.sv -----
// ----------------------------------------------------------------------------
// dspadpcm_ctrl
// Sequencer of the decoder: frame position, sticky error, handshakes and the
// per-sample multiply and accumulate steps.
// ----------------------------------------------------------------------------
module dspadpcm_ctrl
   import dspadpcm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic          req_restart,
   input  logic          req_block_start,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_MUL_HI = 6'b000010,
      ST_ADD_HI = 6'b000100,
      ST_MUL_LO = 6'b001000,
      ST_ADD_LO = 6'b010000,
      ST_ERR    = 6'b100000
   } state_type;

   state_type        state_ff, state_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             err_ff, err_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             slot_free;
   logic             eff_err;
   logic [POS_W-1:0] eff_pos;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // Restart and block start act before the byte itself is looked at.
   assign eff_err = req_restart ? 1'b0 : err_ff;
   assign eff_pos = (req_restart || req_block_start) ? '0 : pos_ff;

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_history = req_restart;
               pos_in           = eff_pos;
               err_in           = eff_err;
               if (!eff_err) begin
                  if (eff_pos == '0) begin
                     if (status.header_bad) begin
                        err_in   = 1'b1;
                        state_in = ST_ERR;
                     end else begin
                        cmd.load_header = 1'b1;
                        pos_in          = POS_W'(1);
                     end
                  end else begin
                     cmd.load_byte = 1'b1;
                     state_in      = ST_MUL_HI;
                  end
               end
            end
         end
         ST_MUL_HI: begin
            cmd.do_mul = 1'b1;
            state_in   = ST_ADD_HI;
         end
         ST_ADD_HI: begin
            if (slot_free) begin
               cmd.do_add   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_MUL_LO;
            end
         end
         ST_MUL_LO: begin
            cmd.do_mul    = 1'b1;
            cmd.nibble_lo = 1'b1;
            state_in      = ST_ADD_LO;
         end
         ST_ADD_LO: begin
            if (slot_free) begin
               cmd.do_add   = 1'b1;
               cmd.last     = 1'b1;
               rsp_valid_in = 1'b1;
               pos_in       = (pos_ff == POS_W'(FRAME_BYTES - 1)) ? '0 : pos_ff + POS_W'(1);
               state_in     = ST_IDLE;
            end
         end
         ST_ERR: begin
            if (slot_free) begin
               cmd.write_err = 1'b1;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- rtl/dspadpcm_datapath.sv -----
// ----------------------------------------------------------------------------
// dspadpcm_datapath
// Coefficient and history registers, the two history multipliers, the
// accumulate, round and saturate step and the result register.
// ----------------------------------------------------------------------------
module dspadpcm_datapath
   import dspadpcm_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write,
   input  logic [CSR_INDEX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_data,
   input  logic [7:0]                 req_frame_byte,
   input  dp_cmd_type                 cmd,
   output dp_status_type              status,
   output logic signed [SAMPLE_W-1:0] rsp_pcm_sample,
   output logic                       rsp_last_of_pair,
   output logic                       rsp_bad_predictor
);

   logic [CSR_DATA_W-1:0]      coefs_ff [NUM_COEF_REGS];
   logic [2*SAMPLE_W-1:0]      init_hist_ff;
   logic signed [SAMPLE_W-1:0] newest_ff, newest_in;
   logic signed [SAMPLE_W-1:0] older_ff, older_in;
   logic [3:0]                 shift_ff;
   logic [2:0]                 pred_ff;
   logic [7:0]                 byte_ff;
   logic signed [2*SAMPLE_W-1:0] prod1_ff, prod2_ff;
   logic signed [ACC_W-1:0]    scaled_ff;
   logic signed [SAMPLE_W-1:0] out_sample_ff;
   logic                       out_last_ff;
   logic                       out_bad_ff;

   logic [CSR_DATA_W-1:0]      coef_row;
   logic [2*SAMPLE_W-1:0]      coef_pair;
   logic signed [SAMPLE_W-1:0] c1, c2;
   logic [3:0]                 nibble;
   logic signed [ACC_W-1:0]    nibble_ext;
   logic signed [ACC_W-1:0]    acc;
   logic signed [RES_W-1:0]    res;
   logic signed [SAMPLE_W-1:0] sat;

   assign status.header_bad = req_frame_byte[7];

   assign rsp_pcm_sample    = out_sample_ff;
   assign rsp_last_of_pair  = out_last_ff;
   assign rsp_bad_predictor = out_bad_ff;

   // Coefficient pair of the current predictor: even index in the low half.
   assign coef_row  = coefs_ff[pred_ff[2:1]];
   assign coef_pair = pred_ff[0] ? coef_row[63:32] : coef_row[31:0];
   assign c1        = signed'(coef_pair[SAMPLE_W-1:0]);
   assign c2        = signed'(coef_pair[2*SAMPLE_W-1:SAMPLE_W]);

   assign nibble     = cmd.nibble_lo ? byte_ff[3:0] : byte_ff[7:4];
   assign nibble_ext = ACC_W'(signed'(nibble));

   assign acc = scaled_ff + ACC_W'(prod1_ff) + ACC_W'(prod2_ff) + ACC_W'(ROUND_BIAS);
   assign res = RES_W'(acc >>> FRAC_BITS);

   always_comb begin
      if (res > RES_W'(SAMPLE_MAX)) begin
         sat = SAMPLE_MAX;
      end else if (res < RES_W'(SAMPLE_MIN)) begin
         sat = SAMPLE_MIN;
      end else begin
         sat = SAMPLE_W'(res);
      end
   end

   always_comb begin
      newest_in = newest_ff;
      older_in  = older_ff;
      if (cmd.load_history) begin
         newest_in = signed'(init_hist_ff[2*SAMPLE_W-1:SAMPLE_W]);
         older_in  = signed'(init_hist_ff[SAMPLE_W-1:0]);
      end else if (cmd.do_add) begin
         newest_in = sat;
         older_in  = newest_ff;
      end
   end

   // Configuration, history and frame header state.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_COEF_REGS; i++) begin
            coefs_ff[i] <= '0;
         end
         init_hist_ff <= '0;
         newest_ff    <= '0;
         older_ff     <= '0;
         shift_ff     <= '0;
         pred_ff      <= '0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_COEFS_0_1:    coefs_ff[0]  <= csr_data;
               CSR_COEFS_2_3:    coefs_ff[1]  <= csr_data;
               CSR_COEFS_4_5:    coefs_ff[2]  <= csr_data;
               CSR_COEFS_6_7:    coefs_ff[3]  <= csr_data;
               CSR_INIT_HISTORY: init_hist_ff <= csr_data[2*SAMPLE_W-1:0];
               default: ;
            endcase
         end
         newest_ff <= newest_in;
         older_ff  <= older_in;
         if (cmd.load_header) begin
            shift_ff <= req_frame_byte[3:0];
            pred_ff  <= req_frame_byte[6:4];
         end
      end
   end

   // Payload registers: byte, products and the result held for the consumer.
   always_ff @(posedge clock) begin
      if (cmd.load_byte) begin
         byte_ff <= req_frame_byte;
      end
      if (cmd.do_mul) begin
         prod1_ff  <= c1 * newest_ff;
         prod2_ff  <= c2 * older_ff;
         scaled_ff <= (nibble_ext <<< shift_ff) <<< FRAC_BITS;
      end
      if (cmd.do_add) begin
         out_sample_ff <= sat;
         out_last_ff   <= cmd.last;
         out_bad_ff    <= 1'b0;
      end else if (cmd.write_err) begin
         out_sample_ff <= '0;
         out_last_ff   <= 1'b1;
         out_bad_ff    <= 1'b1;
      end
   end

endmodule

// ----- rtl/dsp_adpcm_decoder_top.sv -----
// ----------------------------------------------------------------------------
// dsp_adpcm_decoder_top
// Two-tap predictive 4-bit ADPCM decoder taking one encoded byte per
// transaction and returning up to two 16-bit samples per byte.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake          Payload
//   req      in         req_valid/stall    frame_byte, restart, block_start
//   rsp      out        rsp_valid/stall    pcm_sample, last_of_pair, bad_predictor
//   csr      in         csr_valid/ready    csr_index, csr_data
//
// A header byte is taken in the idle state and gives no sample. A data byte
// is accepted in the idle state; then, for each nibble, one step forms the
// two history products and a second accumulates, rounds and saturates.
// The second sample needs the first as its history, so the nibbles are
// decoded in turn and no new byte is taken until both are done. A
// predictor error passes through an error state and gives one error result.
// Reset is synchronous and active high; it clears the coefficients, the
// initial history, the sample history and all control state.
// The result register lets a header byte be accepted while a sample waits; a
// stalled output holds the accumulate step until the register is free.
// csr_ready is always high, and writes are expected only while idle.
// ----------------------------------------------------------------------------
module dsp_adpcm_decoder_top
   import dspadpcm_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,

   // Encoded byte transactions.
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [7:0]                 req_frame_byte,
   input  logic                       req_restart,
   input  logic                       req_block_start,

   // Decoded sample transactions.
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_pcm_sample,
   output logic                       rsp_last_of_pair,
   output logic                       rsp_bad_predictor,

   // Register writes.
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_data
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // Register writes are never held off.
   assign csr_ready = 1'b1;

   // The controller owns the frame position, the sticky error flag and the
   // output valid flag; the datapath owns every value that is computed.
   dspadpcm_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_restart     (req_restart),
      .req_block_start (req_block_start),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .status          (status),
      .cmd             (cmd)
   );

   dspadpcm_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_write         (csr_valid && csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_frame_byte    (req_frame_byte),
      .cmd               (cmd),
      .status            (status),
      .rsp_pcm_sample    (rsp_pcm_sample),
      .rsp_last_of_pair  (rsp_last_of_pair),
      .rsp_bad_predictor (rsp_bad_predictor)
   );

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the two-tap ADPCM decoder. Encoded bytes are
// driven as random and directed frames, every decoded sample is predicted by
// a scoreboard that tracks the decoder's history and frame state, and each
// sample the block returns is compared field by field with the prediction.
// ----------------------------------------------------------------------------
module tb;
   import dspadpcm_pkg::*;

   // Run shape. Each random phase loads its own coefficient set and then
   // sends this many bytes that the decoder actually consumes.
   localparam int PHASE_ITEMS    = 125;
   localparam int NUM_PHASES     = 6;
   // Cycles allowed after the last expected sample before the block is taken
   // as idle; a data byte needs its decode steps plus any output stall.
   localparam int DRAIN_CYCLES   = 16;
   // Cycles with no transaction on any channel before the run is abandoned.
   localparam int WATCHDOG_LIMIT = 2000;

   // Directed opening sequence. Bit 9 is restart, bit 8 is block_start and
   // the low byte is the encoded byte.
   localparam int NUM_DIRECTED = 22;
   localparam logic [9:0] DIRECTED_BYTES [NUM_DIRECTED] = '{
      10'h200,  // restart, header for predictor 0 with no shift
      10'h07F,  // largest positive nibble and -1; the next byte opens with the most negative
      10'h080,
      10'h008,
      10'h11F,  // block_start mid-frame, predictor 1 with the largest shift
      10'h077,  // seven data bytes that fill the frame and saturate
      10'h088,
      10'h0FF,
      10'h000,
      10'h0F7,
      10'h012,
      10'h034,
      10'h07C,  // the frame wraps, so this byte is a header again
      10'h09A,
      10'h18F,  // header with a predictor index above 7 gives an error result
      10'h055,  // dropped while the error is latched
      10'h100,  // block_start alone does not clear the error
      10'h2F0,  // restart clears it, but this header is bad as well
      10'h223,  // restart with a good header
      10'h0A5,
      10'h24B,  // restart in the middle of a frame
      10'h03C
   };

   typedef enum int {
      CFG_DIRECTED,
      CFG_TYPICAL,
      CFG_ALL_ONES,
      CFG_EXTREME,
      CFG_ZERO,
      CFG_RANDOM
   } coef_setting_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] pcm;
      logic                       last;
      logic                       bad;
   } pcm_result_type;

   // -------------------------------------------------------------------------
   // Scoreboard: keeps its own copy of the registers and the decoder state,
   // turns every accepted byte into the samples it should produce, and checks
   // the samples that come back in order.
   // -------------------------------------------------------------------------
   class adpcm_scoreboard;
      pcm_result_type             expected_samples[$];
      logic [CSR_DATA_W-1:0]      coef_bank[NUM_COEF_REGS] = '{default: '0};
      logic [31:0]                start_history = '0;
      logic signed [SAMPLE_W-1:0] newest = '0;
      logic signed [SAMPLE_W-1:0] older = '0;
      logic [POS_W-1:0]           frame_pos = '0;
      logic [3:0]                 shift = '0;
      logic [2:0]                 pred = '0;
      logic                       err = 1'b0;
      int                         failures = 0;
      int                         samples_checked = 0;
      int                         errors_seen = 0;

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx < CSR_INIT_HISTORY)
            coef_bank[idx[1:0]] = data;
         else if (idx == CSR_INIT_HISTORY)
            start_history = data[31:0];
      endfunction

      // Coefficient c1 (which = 0) or c2 (which = 1) of the current predictor.
      function logic signed [SAMPLE_W-1:0] coef(int which);
         logic [CSR_DATA_W-1:0] bank;
         int                    pos;
         bank = coef_bank[pred[2:1]];
         pos  = (pred[0] * 2 + which) * SAMPLE_W;
         return bank[pos +: SAMPLE_W];
      endfunction

      // One nibble through the predictor: scale, add both history taps,
      // round, floor shift, saturate, then shift the history along.
      function void predict_sample(logic [3:0] nib, logic last);
         logic signed [3:0] snib;
         longint            acc;
         longint            res;
         pcm_result_type    r;
         snib = nib;
         acc  = longint'(snib) * (longint'(1) << shift) * (longint'(1) << FRAC_BITS);
         acc += longint'(coef(0)) * longint'(newest);
         acc += longint'(coef(1)) * longint'(older);
         acc += ROUND_BIAS;
         res  = acc >>> FRAC_BITS;
         if (res > longint'(SAMPLE_MAX))
            res = SAMPLE_MAX;
         else if (res < longint'(SAMPLE_MIN))
            res = SAMPLE_MIN;
         older  = newest;
         newest = res[SAMPLE_W-1:0];
         r.pcm  = newest;
         r.last = last;
         r.bad  = 1'b0;
         expected_samples.push_back(r);
      endfunction

      // Notes one accepted byte. Returns 0 when the decoder drops it.
      function bit note_byte(logic [7:0] b, logic rs, logic bs);
         pcm_result_type r;
         if (rs) begin
            newest    = start_history[31:16];
            older     = start_history[15:0];
            err       = 1'b0;
            frame_pos = '0;
         end
         if (bs)
            frame_pos = '0;
         if (err)
            return 0;
         if (frame_pos == 0) begin
            if (b[7:4] > 4'd7) begin
               err    = 1'b1;
               r.pcm  = '0;
               r.last = 1'b1;
               r.bad  = 1'b1;
               expected_samples.push_back(r);
               errors_seen++;
            end else begin
               shift     = b[3:0];
               pred      = b[6:4];
               frame_pos = POS_W'(1);
            end
            return 1;
         end
         predict_sample(b[7:4], 1'b0);
         predict_sample(b[3:0], 1'b1);
         frame_pos = frame_pos + POS_W'(1);  // wraps back to the header slot
         return 1;
      endfunction

      function void check_sample(logic signed [SAMPLE_W-1:0] pcm, logic last, logic bad);
         pcm_result_type want;
         if (expected_samples.size() == 0) begin
            failures++;
            $display("%0t: sample with none expected: pcm=%0d last=%0b bad=%0b",
                     $time, pcm, last, bad);
            return;
         end
         want = expected_samples.pop_front();
         samples_checked++;
         if (pcm !== want.pcm || last !== want.last || bad !== want.bad) begin
            failures++;
            $display("%0t: sample mismatch: expected pcm=%0d last=%0b bad=%0b,",
                     $time, want.pcm, want.last, want.bad,
                     " got pcm=%0d last=%0b bad=%0b", pcm, last, bad);
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Signals and the block under test.
   // -------------------------------------------------------------------------
   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic [7:0]                 req_frame_byte;
   logic                       req_restart;
   logic                       req_block_start;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic signed [SAMPLE_W-1:0] rsp_pcm_sample;
   logic                       rsp_last_of_pair;
   logic                       rsp_bad_predictor;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CSR_INDEX_W-1:0]     csr_index;
   logic [CSR_DATA_W-1:0]      csr_data;

   adpcm_scoreboard sb;
   bit              quiet = 1'b0;  // no idling on either side when set
   int              gap_pct = 0;   // chance of an idle burst before a byte
   int              bytes_sent = 0;

   dsp_adpcm_decoder_top u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_frame_byte    (req_frame_byte),
      .req_restart       (req_restart),
      .req_block_start   (req_block_start),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_pcm_sample    (rsp_pcm_sample),
      .rsp_last_of_pair  (rsp_last_of_pair),
      .rsp_bad_predictor (rsp_bad_predictor),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Driving tasks. Inputs change on the falling edge; handshakes are judged
   // on the rising edge from the values that were present just before it.
   // -------------------------------------------------------------------------

   // Sends one byte transaction, possibly after a short idle burst. The
   // payload is held until the decoder stops stalling, and valid is left high
   // so that a following byte can go straight out.
   task automatic send_byte(input logic [7:0] b, input logic rs, input logic bs,
                            output bit used);
      int gap;
      if (!quiet && gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         gap = $urandom_range(1, 3);
         repeat (gap) begin
            @(negedge clock);
            req_valid = 1'b0;
         end
      end
      @(negedge clock);
      req_valid       = 1'b1;
      req_frame_byte  = b;
      req_restart     = rs;
      req_block_start = bs;
      do @(posedge clock); while (req_stall);
      used = sb.note_byte(b, rs, bs);
      bytes_sent++;
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = data;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, data);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Waits until every expected sample has arrived, then long enough for a
   // header or a dropped byte still in flight to settle.
   task automatic wait_until_drained();
      while (sb.expected_samples.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Random coefficient of moderate size, so that predictions do not all
   // saturate.
   function automatic logic [SAMPLE_W-1:0] moderate_coef(int span);
      int v;
      v = int'($urandom_range(0, 2 * span)) - span;
      return v[SAMPLE_W-1:0];
   endfunction

   // Writes all four coefficient registers and the initial history.
   task automatic load_settings(input coef_setting_type kind);
      logic [CSR_DATA_W-1:0] bank;
      logic [31:0]           hist;
      for (int k = 0; k < NUM_COEF_REGS; k++) begin
         case (kind)
            CFG_DIRECTED: begin
               // Predictor 0 passes the newest sample through at unity gain,
               // predictor 1 takes the most positive c1 and the most
               // negative c2; the rest are moderate.
               if (k == 0)
                  bank = {16'h8000, 16'h7FFF, 16'h0000, 16'h0800};
               else
                  bank = {moderate_coef(2048), moderate_coef(4096),
                          moderate_coef(2048), moderate_coef(4096)};
            end
            CFG_TYPICAL:
               bank = {moderate_coef(2048), moderate_coef(4096),
                       moderate_coef(2048), moderate_coef(4096)};
            CFG_ALL_ONES: bank = '1;
            CFG_EXTREME:  bank = (k[0]) ? 64'h7FFF_8000_7FFF_8000 : 64'h8000_7FFF_8000_7FFF;
            CFG_ZERO:     bank = '0;
            default:      bank = {$urandom, $urandom};
         endcase
         write_csr(CSR_COEFS_0_1 + CSR_INDEX_W'(k), bank);
      end
      case (kind)
         CFG_DIRECTED, CFG_EXTREME: hist = 32'h7FFF_8000;
         CFG_ALL_ONES:              hist = '1;
         CFG_ZERO:                  hist = '0;
         default:                   hist = $urandom;
      endcase
      write_csr(CSR_INIT_HISTORY, {32'h0, hist});
   endtask

   // One random phase. Most of the stream is well-formed frames: a header
   // with a good predictor index followed by data bytes with random content.
   // Now and then a bad header, a block_start or a restart breaks a frame,
   // and while an error is latched the stream usually recovers with a
   // restart. Bytes that the decoder drops are not counted.
   task automatic run_phase(input coef_setting_type kind, input int gap);
      logic [7:0] b;
      logic       rs;
      logic       bs;
      bit         used;
      int         consumed;
      wait_until_drained();
      load_settings(kind);
      gap_pct  = gap;
      consumed = 0;
      while (consumed < PHASE_ITEMS) begin
         b  = 8'($urandom_range(0, 255));
         rs = 1'b0;
         bs = 1'b0;
         if (sb.err) begin
            rs = ($urandom_range(0, 3) != 0);
            bs = ($urandom_range(0, 3) == 0);
         end else if (sb.frame_pos == 0) begin
            if ($urandom_range(0, 99) >= 6)
               b[7] = 1'b0;
            if ($urandom_range(0, 3) != 0)
               b[3:0] = 4'($urandom_range(0, 11));
            rs = ($urandom_range(0, 19) == 0);
            bs = ($urandom_range(0, 3) == 0);
         end else begin
            rs = ($urandom_range(0, 59) == 0);
            bs = ($urandom_range(0, 39) == 0);
         end
         send_byte(b, rs, bs, used);
         if (used)
            consumed++;
      end
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   // -------------------------------------------------------------------------
   // Output side: the stall comes in random bursts, with calm stretches in
   // between, and stops entirely for the final phase.
   // -------------------------------------------------------------------------
   initial begin
      int burst;
      int calm;
      rsp_stall = 1'b0;
      burst     = 0;
      calm      = 0;
      forever begin
         @(negedge clock);
         if (quiet) begin
            rsp_stall = 1'b0;
         end else if (burst > 0) begin
            rsp_stall = 1'b1;
            burst--;
         end else if (calm > 0) begin
            rsp_stall = 1'b0;
            calm--;
         end else begin
            rsp_stall = 1'b0;
            case ($urandom_range(0, 9))
               0, 1, 2: burst = $urandom_range(1, 3);
               3:       calm = $urandom_range(20, 60);
               default: ;
            endcase
         end
      end
   end

   // Every accepted sample transaction goes to the scoreboard.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_sample(rsp_pcm_sample, rsp_last_of_pair, rsp_bad_predictor);
   end

   // The watchdog restarts its count whenever any channel completes a
   // transaction, so only a genuine hang reaches the limit.
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("%0t: no transaction for %0d cycles, %0d samples still expected",
               $time, WATCHDOG_LIMIT, sb.expected_samples.size());
      $display("Test completed with failures");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Main sequence.
   // -------------------------------------------------------------------------
   initial begin
      bit used;
      sb              = new;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_frame_byte  = '0;
      req_restart     = 1'b0;
      req_block_start = 1'b0;
      csr_valid       = 1'b0;
      csr_index       = '0;
      csr_data        = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part: extremes of the nibbles and the shift, frame wrap,
      // block_start, restart and the sticky predictor error.
      load_settings(CFG_DIRECTED);
      gap_pct = 30;
      for (int i = 0; i < NUM_DIRECTED; i++)
         send_byte(DIRECTED_BYTES[i][7:0], DIRECTED_BYTES[i][9],
                   DIRECTED_BYTES[i][8], used);
      @(negedge clock);
      req_valid = 1'b0;

      // Random phases, each under its own register setting. The third runs
      // without gaps on the input side, and the last without any idling.
      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p == NUM_PHASES - 1)
            quiet = 1'b1;
         case (p)
            0:       run_phase(CFG_TYPICAL, 25);
            1:       run_phase(CFG_ALL_ONES, 40);
            2:       run_phase(CFG_EXTREME, 0);
            3:       run_phase(CFG_ZERO, 25);
            4:       run_phase(CFG_RANDOM, 25);
            default: run_phase(CFG_TYPICAL, 0);
         endcase
      end

      wait_until_drained();
      $display("Sent %0d encoded bytes over %0d register settings, with directed frames first.",
               bytes_sent, NUM_PHASES + 1);
      $display("Checked %0d samples, %0d of them predictor errors; %0d mismatches.",
               sb.samples_checked, sb.errors_seen, sb.failures);
      if (sb.failures == 0 && sb.expected_samples.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/dspadpcm_pkg.sv
rtl/dspadpcm_ctrl.sv
rtl/dspadpcm_datapath.sv
rtl/dsp_adpcm_decoder_top.sv
verif/tb.sv
